// ----- hdl/ac_pkg.sv -----
// ac_pkg: shared types, S-box table and AES round helpers for the AES-256 CTR byte stream.
// No dependencies.
package ac_pkg;

	typedef struct packed {
		logic start;
		logic cancel;
	} ac_ctl_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [3:0]  LAST_ROUND    = 4'd14;
	localparam logic [31:0] COUNTER_START = 32'd2;

	localparam logic [2:0] REG_KEY0  = 3'd0;
	localparam logic [2:0] REG_KEY1  = 3'd1;
	localparam logic [2:0] REG_KEY2  = 3'd2;
	localparam logic [2:0] REG_KEY3  = 3'd3;
	localparam logic [2:0] REG_NHIGH = 3'd4;
	localparam logic [2:0] REG_NLOW  = 3'd5;

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] b);
		xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// byte k of a block sits at [127-8k -: 8]
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (4 * c + r) -: 8] = SBOX[s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]];
			end
		end
		sub_shift = t;
	endfunction

	function automatic logic [127:0] mix_cols(input logic [127:0] t);
		logic [127:0] m;
		logic [7:0] a0, a1, a2, a3, al;
		m = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = t[127 - 32 * c -: 8];
			a1 = t[119 - 32 * c -: 8];
			a2 = t[111 - 32 * c -: 8];
			a3 = t[103 - 32 * c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			m[127 - 32 * c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			m[119 - 32 * c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			m[111 - 32 * c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			m[103 - 32 * c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		mix_cols = m;
	endfunction

endpackage

// ----- hdl/aes256_ctr_byte_stream_xor.sv -----
// AES-256 CTR byte stream: one byte a beat, output registered, accepted byte shown the next cycle.
// Refill of 16 keystream bytes in ac_core runs as load, 14 rounds and hand-over, and is
// started as soon as the previous block is used up; no bytes are accepted during a refill.
// Writes to cfg_idx 0..5 empty the keystream, reload the counter to 2 and restart the refill.
// Reset (arst_n low, async) clears key, nonce and keystream; ready rises after the first refill.
module aes256_ctr_byte_stream_xor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // data_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic        m_tlast,   // out_last
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [63:0] cfg_data
);

	logic [63:0]  key0_q, key1_q, key2_q, key3_q, nhi_q;
	logic [31:0]  nlo_q, ctr_q;
	logic [127:0] ks_q;
	logic         ks_valid_q;
	logic [3:0]   off_q;
	logic         m_valid_q;
	logic [7:0]   m_data_q;
	logic         m_last_q;

	ac_pkg::ac_ctl_t ctl;
	logic            busy, done, cfg_hit, s_acc;
	logic [127:0]    result;

	assign cfg_hit   = cfg_we && (cfg_idx <= ac_pkg::REG_NLOW);
	assign ctl       = '{start: !ks_valid_q && !busy && !done && !cfg_hit, cancel: cfg_hit};
	assign s_tready  = ks_valid_q && (!m_valid_q || m_tready);
	assign s_acc     = s_tvalid && s_tready;

	ac_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.key    ({key0_q, key1_q, key2_q, key3_q}),
		.blk    ({nhi_q, nlo_q, ctr_q}),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			nhi_q      <= '0;
			nlo_q      <= '0;
			ctr_q      <= ac_pkg::COUNTER_START;
			ks_valid_q <= 1'b0;
			off_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (s_acc) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				unique case (cfg_idx)
					ac_pkg::REG_KEY0:  key0_q <= cfg_data;
					ac_pkg::REG_KEY1:  key1_q <= cfg_data;
					ac_pkg::REG_KEY2:  key2_q <= cfg_data;
					ac_pkg::REG_KEY3:  key3_q <= cfg_data;
					ac_pkg::REG_NHIGH: nhi_q  <= cfg_data;
					default:           nlo_q  <= cfg_data[31:0];
				endcase
				ctr_q      <= ac_pkg::COUNTER_START;
				ks_valid_q <= 1'b0;
			end else begin
				if (ctl.start) begin
					ctr_q <= ctr_q + 32'd1;
				end
				if (done) begin
					ks_valid_q <= 1'b1;
					off_q      <= '0;
				end else if (s_acc) begin
					off_q <= off_q + 4'd1;
					if (off_q == 4'd15) begin
						ks_valid_q <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			ks_q <= result;
		end
		if (s_acc) begin
			m_data_q <= s_tdata ^ ks_q[{~off_q, 3'b000} +: 8];
			m_last_q <= s_tlast;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

// ----- hdl/ac_core.sv -----
// ac_core: iterative AES-256 encryptor, one round per cycle, round keys generated on the fly.
// Depends on ac_pkg.
module ac_core (
	input  logic             clk,
	input  logic             arst_n,
	input  ac_pkg::ac_ctl_t  ctl,
	input  logic [255:0]     key,
	input  logic [127:0]     blk,
	output logic             busy,
	output logic             done,
	output logic [127:0]     result
);

	logic         busy_q;
	logic         done_q;
	logic [3:0]   rnd_q;
	logic [127:0] s_q;
	logic [255:0] kw_q;

	logic [31:0]  t_w, n0, n1, n2, n3;
	logic [7:0]   rcon;
	logic [127:0] sh, mx, rk;

	always_comb begin
		rcon = 8'h01 << (rnd_q[3:1] - 3'd1);
		if (!rnd_q[0]) begin
			t_w = ac_pkg::sub_word({kw_q[23:0], kw_q[31:24]}) ^ {rcon, 24'h0};
		end else begin
			t_w = ac_pkg::sub_word(kw_q[31:0]);
		end
		n0 = kw_q[255:224] ^ t_w;
		n1 = kw_q[223:192] ^ n0;
		n2 = kw_q[191:160] ^ n1;
		n3 = kw_q[159:128] ^ n2;
		rk = (rnd_q == 4'd1) ? kw_q[127:0] : {n0, n1, n2, n3};
		sh = ac_pkg::sub_shift(s_q);
		mx = (rnd_q == ac_pkg::LAST_ROUND) ? sh : ac_pkg::mix_cols(sh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (ctl.cancel) begin
				busy_q <= 1'b0;
			end else if (ctl.start) begin
				busy_q <= 1'b1;
				rnd_q  <= 4'd1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == ac_pkg::LAST_ROUND) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			s_q  <= blk ^ key[255:128];
			kw_q <= key;
		end else if (busy_q) begin
			s_q <= mx ^ rk;
			if (rnd_q != 4'd1) begin
				kw_q <= {kw_q[127:0], n0, n1, n2, n3};
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = s_q;

endmodule

// ----- hdl/ac_checker.sv -----
// ac_checker: port-level assertions for aes256_ctr_byte_stream_xor, bound to the top level.
// Depends on aes256_ctr_byte_stream_xor and ac_pkg.
module ac_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       cfg_we,
	input logic [2:0] cfg_idx
);

	// held output beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no output");

	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx <= ac_pkg::REG_NLOW) |=> !s_tready)
		else $error("keystream not flushed by config write");

endmodule

bind aes256_ctr_byte_stream_xor ac_checker u_ac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.cfg_we   (cfg_we),
	.cfg_idx  (cfg_idx)
);
